// ----- rtl/core/isbp_pkg.sv -----
package isbp_pkg;

   localparam int ROW_W = 96;

   localparam logic [1:0] ACT_PASS       = 2'd0;
   localparam logic [1:0] ACT_SAMPLE     = 2'd1;
   localparam logic [1:0] ACT_CONNECT    = 2'd2;
   localparam logic [1:0] ACT_DISCONNECT = 2'd3;

   localparam logic CSR_LINK_MTU      = 1'b0;
   localparam logic CSR_FLUSH_TIMEOUT = 1'b1;

   localparam logic [9:0]  MTU_MIN        = 10'd25;
   localparam logic [9:0]  MTU_OVERHEAD   = 10'd13;
   localparam logic [15:0] RECIP_THREE    = 16'd171;
   localparam logic [6:0]  CAP_MIN        = 7'd1;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd15;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DRAIN
   } state_type;

   // Rows per packet before clamping: (mtu - 13) / 12, taken as a shift by two
   // followed by an exact multiply-by-reciprocal division by three.
   function automatic logic [6:0] raw_cap(input logic [9:0] mtu);
      logic [9:0]  diff;
      logic [15:0] prod;
      diff = mtu - MTU_OVERHEAD;
      prod = {8'b0, diff[9:2]} * RECIP_THREE;
      return (mtu < MTU_MIN) ? CAP_MIN : prod[15:9];
   endfunction

endpackage

// ----- rtl/core/imu_sample_batch_packetizer_core.sv -----
// Channel    Direction  Handshake           Moves
// req_*      in         req_valid/req_stall one request: action, sample, clocks, battery
// rsp_*      out        rsp_valid/rsp_stall one packet row with its header fields
// csr_*      in         csr_wr_en           one register write, no read-back
//
// A request is taken in ST_IDLE; a pass or sample with the link up then enters ST_EVAL
// for the flush decision. A sent packet of N rows streams from the row memory's read port
// in ST_DRAIN, one row per cycle while rsp_stall stays low.
// Reset is synchronous and clears control state but not latched fields or the row memory.
// rsp_stall holds the current row in the memory read register; req_stall is high
// whenever a request is still being evaluated or its packet is still streaming.
module imu_sample_batch_packetizer_core #(
   parameter int MAX_ROWS = 19
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic [31:0]        req_time_us,
   input  logic [31:0]        req_time_ms,
   input  logic [6:0]         req_battery_pct,
   input  logic               req_send_accepted,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_first_index,
   output logic [31:0]        rsp_first_time_us,
   output logic [6:0]         rsp_battery_level,
   output logic [4:0]         rsp_sample_total,
   output logic [4:0]         rsp_row_number,
   output logic signed [15:0] rsp_out_accel_x,
   output logic signed [15:0] rsp_out_accel_y,
   output logic signed [15:0] rsp_out_accel_z,
   output logic signed [15:0] rsp_out_gyro_x,
   output logic signed [15:0] rsp_out_gyro_y,
   output logic signed [15:0] rsp_out_gyro_z,
   output logic               rsp_last_row,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int CW = $clog2(MAX_ROWS + 1);
   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [CW-1:0] cap_ff, cap_in;
   logic [15:0]   timeout_ff, timeout_in;
   logic [6:0]    new_cap;

   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   logic [isbp_pkg::ROW_W-1:0] mem_wr_data;
   logic                       mem_rd_en;
   logic [AW-1:0]              mem_rd_addr;
   logic [isbp_pkg::ROW_W-1:0] mem_rd_data;
   logic [isbp_pkg::ROW_W-1:0] req_row;

   assign new_cap = isbp_pkg::raw_cap(csr_wdata[9:0]);

   always_comb begin
      cap_in     = cap_ff;
      timeout_in = timeout_ff;
      if (csr_wr_en) begin
         case (csr_index)
            isbp_pkg::CSR_LINK_MTU: begin
               cap_in = (new_cap > 7'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(new_cap);
            end
            isbp_pkg::CSR_FLUSH_TIMEOUT: begin
               timeout_in = csr_wdata;
            end
            default: begin
               cap_in = cap_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CW'(1);
         timeout_ff <= isbp_pkg::TIMEOUT_RESET;
      end else begin
         cap_ff     <= cap_in;
         timeout_ff <= timeout_in;
      end
   end

   assign req_row = {req_accel_x, req_accel_y, req_accel_z,
                     req_gyro_x, req_gyro_y, req_gyro_z};

   isbp_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .CW       (CW),
      .AW       (AW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_row           (req_row),
      .req_time_us       (req_time_us),
      .req_time_ms       (req_time_ms),
      .req_battery_pct   (req_battery_pct),
      .req_send_accepted (req_send_accepted),
      .cap               (cap_ff),
      .timeout           (timeout_ff),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_first_index   (rsp_first_index),
      .rsp_first_time_us (rsp_first_time_us),
      .rsp_battery_level (rsp_battery_level),
      .rsp_sample_total  (rsp_sample_total),
      .rsp_row_number    (rsp_row_number),
      .rsp_last_row      (rsp_last_row)
   );

   isbp_row_mem #(
      .DEPTH (MAX_ROWS),
      .AW    (AW)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_out_accel_x = mem_rd_data[95:80];
   assign rsp_out_accel_y = mem_rd_data[79:64];
   assign rsp_out_accel_z = mem_rd_data[63:48];
   assign rsp_out_gyro_x  = mem_rd_data[47:32];
   assign rsp_out_gyro_y  = mem_rd_data[31:16];
   assign rsp_out_gyro_z  = mem_rd_data[15:0];

endmodule

// ----- rtl/core/isbp_row_mem.sv -----
module isbp_row_mem #(
   parameter int DEPTH = 19,
   parameter int AW    = 5
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [isbp_pkg::ROW_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [isbp_pkg::ROW_W-1:0] rd_data
);

   logic [isbp_pkg::ROW_W-1:0] mem_ff [DEPTH];
   logic [isbp_pkg::ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/isbp_ctrl.sv -----
module isbp_ctrl #(
   parameter int MAX_ROWS = 19,
   parameter int CW       = 5,
   parameter int AW       = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_action,
   input  logic [isbp_pkg::ROW_W-1:0] req_row,
   input  logic [31:0]                req_time_us,
   input  logic [31:0]                req_time_ms,
   input  logic [6:0]                 req_battery_pct,
   input  logic                       req_send_accepted,
   input  logic [CW-1:0]              cap,
   input  logic [15:0]                timeout,
   output logic                       mem_wr_en,
   output logic [AW-1:0]              mem_wr_addr,
   output logic [isbp_pkg::ROW_W-1:0] mem_wr_data,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_rd_addr,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [31:0]                rsp_first_index,
   output logic [31:0]                rsp_first_time_us,
   output logic [6:0]                 rsp_battery_level,
   output logic [4:0]                 rsp_sample_total,
   output logic [4:0]                 rsp_row_number,
   output logic                       rsp_last_row
);

   isbp_pkg::state_type state_ff, state_in;

   logic [CW-1:0] row_count_ff, row_count_in;
   logic [31:0]   running_index_ff, running_index_in;
   logic [31:0]   first_index_ff, first_index_in;
   logic [31:0]   first_time_ff, first_time_in;
   logic [31:0]   last_flush_ff, last_flush_in;
   logic          link_up_ff, link_up_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   time_ms_ff, time_ms_in;
   logic [6:0]    battery_ff, battery_in;
   logic          accepted_ff, accepted_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] shown_ff, shown_in;

   logic          accept;
   logic          append;
   logic          flush;
   logic          issue;
   logic          take;
   logic [31:0]   elapsed;

   assign accept  = req_valid && !req_stall;
   assign append  = accept && link_up_ff && (req_action == isbp_pkg::ACT_SAMPLE)
                    && (row_count_ff < CW'(MAX_ROWS));
   assign elapsed = time_ms_ff - last_flush_ff;
   assign flush   = (row_count_ff >= cap)
                    || ((row_count_ff != '0) && (elapsed >= {16'b0, timeout}));
   assign take    = rsp_valid_ff && !rsp_stall;
   assign issue   = (state_ff == isbp_pkg::ST_DRAIN) && (rd_idx_ff != total_ff)
                    && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         isbp_pkg::ST_IDLE: begin
            if (req_valid && link_up_ff
                && (req_action inside {isbp_pkg::ACT_PASS, isbp_pkg::ACT_SAMPLE})) begin
               state_in = isbp_pkg::ST_EVAL;
            end
         end
         isbp_pkg::ST_EVAL: begin
            state_in = (flush && accepted_ff) ? isbp_pkg::ST_DRAIN : isbp_pkg::ST_IDLE;
         end
         isbp_pkg::ST_DRAIN: begin
            if ((rd_idx_ff == total_ff) && (!rsp_valid_ff || !rsp_stall)) begin
               state_in = isbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = isbp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = (state_ff != isbp_pkg::ST_IDLE);
      mem_wr_en   = append;
      mem_wr_addr = row_count_ff[AW-1:0];
      mem_wr_data = req_row;
      mem_rd_en   = issue;
      mem_rd_addr = rd_idx_ff[AW-1:0];
   end

   always_comb begin
      row_count_in     = row_count_ff;
      running_index_in = running_index_ff;
      first_index_in   = first_index_ff;
      first_time_in    = first_time_ff;
      last_flush_in    = last_flush_ff;
      link_up_in       = link_up_ff;
      rd_idx_in        = rd_idx_ff;
      rsp_valid_in     = rsp_valid_ff;
      time_ms_in       = time_ms_ff;
      battery_in       = battery_ff;
      accepted_in      = accepted_ff;
      total_in         = total_ff;
      shown_in         = shown_ff;

      if (accept) begin
         time_ms_in  = req_time_ms;
         battery_in  = req_battery_pct;
         accepted_in = req_send_accepted;
         case (req_action)
            isbp_pkg::ACT_CONNECT: begin
               running_index_in = '0;
               link_up_in       = 1'b1;
            end
            isbp_pkg::ACT_DISCONNECT: begin
               link_up_in   = 1'b0;
               row_count_in = '0;
            end
            default: begin
               if (append) begin
                  if (row_count_ff == '0) begin
                     first_index_in = running_index_ff;
                     first_time_in  = req_time_us;
                  end
                  row_count_in     = row_count_ff + CW'(1);
                  running_index_in = running_index_ff + 32'd1;
               end
            end
         endcase
      end

      if ((state_ff == isbp_pkg::ST_EVAL) && flush) begin
         if (accepted_ff) begin
            total_in      = row_count_ff;
            rd_idx_in     = '0;
            row_count_in  = '0;
            last_flush_in = time_ms_ff;
         end else if (row_count_ff >= CW'(MAX_ROWS)) begin
            row_count_in  = '0;
            last_flush_in = time_ms_ff;
         end
      end

      if (issue) begin
         rd_idx_in    = rd_idx_ff + CW'(1);
         shown_in     = rd_idx_ff;
         rsp_valid_in = 1'b1;
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= isbp_pkg::ST_IDLE;
         row_count_ff     <= '0;
         running_index_ff <= '0;
         first_index_ff   <= '0;
         first_time_ff    <= '0;
         last_flush_ff    <= '0;
         link_up_ff       <= 1'b0;
         rd_idx_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         row_count_ff     <= row_count_in;
         running_index_ff <= running_index_in;
         first_index_ff   <= first_index_in;
         first_time_ff    <= first_time_in;
         last_flush_ff    <= last_flush_in;
         link_up_ff       <= link_up_in;
         rd_idx_ff        <= rd_idx_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ms_ff  <= time_ms_in;
      battery_ff  <= battery_in;
      accepted_ff <= accepted_in;
      total_ff    <= total_in;
      shown_ff    <= shown_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_index   = first_index_ff;
   assign rsp_first_time_us = first_time_ff;
   assign rsp_battery_level = battery_ff;
   assign rsp_sample_total  = 5'(total_ff);
   assign rsp_row_number    = 5'(shown_ff);
   assign rsp_last_row      = (({1'b0, shown_ff} + (CW+1)'(1)) == {1'b0, total_ff});

endmodule

// ----- tb/sv/imu_sample_batch_packetizer_core_test.sv -----
module imu_sample_batch_packetizer_core_test;

   localparam int ROWS = 19;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct {
      logic [1:0]         action;
      logic signed [15:0] gx, gy, gz, ax, ay, az;
      logic [31:0]        t_us, t_ms;
      logic [6:0]         battery;
      logic               accept;
   } imu_request_type;

   typedef struct {
      logic [31:0]        first_index, first_us;
      logic [6:0]         battery;
      logic [4:0]         total, row;
      logic signed [15:0] ax, ay, az, gx, gy, gz;
      logic               last;
   } packet_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_action;
   logic signed [15:0] req_gyro_x, req_gyro_y, req_gyro_z;
   logic signed [15:0] req_accel_x, req_accel_y, req_accel_z;
   logic [31:0]        req_time_us, req_time_ms;
   logic [6:0]         req_battery_pct;
   logic               req_send_accepted;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [31:0]        rsp_first_index, rsp_first_time_us;
   logic [6:0]         rsp_battery_level;
   logic [4:0]         rsp_sample_total, rsp_row_number;
   logic signed [15:0] rsp_out_accel_x, rsp_out_accel_y, rsp_out_accel_z;
   logic signed [15:0] rsp_out_gyro_x, rsp_out_gyro_y, rsp_out_gyro_z;
   logic               rsp_last_row;
   logic               csr_wr_en;
   logic               csr_index;
   logic [15:0]        csr_wdata;

   imu_request_type batch_rows [ROWS];
   int unsigned     batch_len;
   logic [31:0]     sample_seq, batch_seq, batch_us, flush_ms;
   logic            link_is_up;
   logic [9:0]      mtu_reg;
   logic [15:0]     timeout_reg;
   packet_row_type  pending_rows [$];

   int unsigned req_gap_max = 12;
   int unsigned rsp_gap_max = 12;
   int unsigned mismatch_count = 0;
   int unsigned requests_sent = 0;
   int unsigned packets_expected = 0;
   int unsigned rows_checked = 0;
   int unsigned settings_written = 0;

   imu_sample_batch_packetizer_core #(.MAX_ROWS(ROWS)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_gyro_x(req_gyro_x),
      .req_gyro_y(req_gyro_y),
      .req_gyro_z(req_gyro_z),
      .req_accel_x(req_accel_x),
      .req_accel_y(req_accel_y),
      .req_accel_z(req_accel_z),
      .req_time_us(req_time_us),
      .req_time_ms(req_time_ms),
      .req_battery_pct(req_battery_pct),
      .req_send_accepted(req_send_accepted),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_first_index(rsp_first_index),
      .rsp_first_time_us(rsp_first_time_us),
      .rsp_battery_level(rsp_battery_level),
      .rsp_sample_total(rsp_sample_total),
      .rsp_row_number(rsp_row_number),
      .rsp_out_accel_x(rsp_out_accel_x),
      .rsp_out_accel_y(rsp_out_accel_y),
      .rsp_out_accel_z(rsp_out_accel_z),
      .rsp_out_gyro_x(rsp_out_gyro_x),
      .rsp_out_gyro_y(rsp_out_gyro_y),
      .rsp_out_gyro_z(rsp_out_gyro_z),
      .rsp_last_row(rsp_last_row),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Handles connect and disconnect, appends a sample, decides on a flush and queues the rows of any packet sent.
   function automatic void packetize_request(input imu_request_type r);
      int unsigned cap;
      int unsigned k;
      logic [31:0] elapsed;
      packet_row_type row;
      if (r.action == isbp_pkg::ACT_CONNECT) begin
         sample_seq = 0;
         link_is_up = 1'b1;
         return;
      end
      if (r.action == isbp_pkg::ACT_DISCONNECT) begin
         link_is_up = 1'b0;
         batch_len = 0;
         return;
      end
      if (!link_is_up) return;
      if (r.action == isbp_pkg::ACT_SAMPLE && batch_len < ROWS) begin
         if (batch_len == 0) begin
            batch_us = r.t_us;
            batch_seq = sample_seq;
         end
         batch_rows[batch_len] = r;
         batch_len++;
         sample_seq++;
      end
      cap = (mtu_reg < 25) ? 1 : (mtu_reg - 13) / 12;
      if (cap > ROWS) cap = ROWS;
      if (cap < 1) cap = 1;
      elapsed = r.t_ms - flush_ms;
      if (!(batch_len >= cap || (batch_len > 0 && elapsed >= timeout_reg))) return;
      if (r.accept) begin
         for (k = 0; k < batch_len; k++) begin
            row.first_index = batch_seq;
            row.first_us = batch_us;
            row.battery = r.battery;
            row.total = batch_len[4:0];
            row.row = k[4:0];
            row.ax = batch_rows[k].ax;
            row.ay = batch_rows[k].ay;
            row.az = batch_rows[k].az;
            row.gx = batch_rows[k].gx;
            row.gy = batch_rows[k].gy;
            row.gz = batch_rows[k].gz;
            row.last = (k + 1 == batch_len);
            pending_rows.push_back(row);
         end
         batch_len = 0;
         flush_ms = r.t_ms;
         packets_expected++;
      end else if (batch_len >= ROWS) begin
         batch_len = 0;
         flush_ms = r.t_ms;
      end
   endfunction

   function automatic imu_request_type make_request(input logic [1:0] action,
                                                    input logic [31:0] t_ms,
                                                    input logic accept);
      imu_request_type r;
      r.action = action;
      r.gx = 16'($urandom);
      r.gy = 16'($urandom);
      r.gz = 16'($urandom);
      r.ax = 16'($urandom);
      r.ay = 16'($urandom);
      r.az = 16'($urandom);
      r.t_us = $urandom;
      r.t_ms = t_ms;
      r.battery = 7'($urandom_range(0, 127));
      r.accept = accept;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic send_request(input imu_request_type r);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action = r.action;
      req_gyro_x = r.gx;
      req_gyro_y = r.gy;
      req_gyro_z = r.gz;
      req_accel_x = r.ax;
      req_accel_y = r.ay;
      req_accel_z = r.az;
      req_time_us = r.t_us;
      req_time_ms = r.t_ms;
      req_battery_pct = r.battery;
      req_send_accepted = r.accept;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      packetize_request(r);
      requests_sent++;
   endtask

   // Waits until every queued row has arrived and the last request has settled.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rows.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_register(input logic index, input logic [15:0] value);
      settle();
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (index == isbp_pkg::CSR_LINK_MTU) mtu_reg = value[9:0];
      else timeout_reg = value;
      settings_written++;
   endtask

   task automatic test_link_down();
      send_request(make_request(isbp_pkg::ACT_SAMPLE, 32'd0, 1'b1));
      send_request(make_request(isbp_pkg::ACT_PASS, 32'd1, 1'b1));
      send_request(make_request(isbp_pkg::ACT_DISCONNECT, 32'd2, 1'b1));
   endtask

   task automatic test_field_extremes();
      imu_request_type r;
      send_request(make_request(isbp_pkg::ACT_CONNECT, 32'd3, 1'b1));
      r = make_request(isbp_pkg::ACT_SAMPLE, 32'd4, 1'b1);
      r.gx = 16'sh7FFF;
      r.gy = 16'sh7FFF;
      r.gz = 16'sh7FFF;
      r.ax = 16'sh8000;
      r.ay = 16'sh8000;
      r.az = 16'sh8000;
      r.t_us = 32'hFFFF_FFFF;
      r.battery = 7'd100;
      send_request(r);
      r.gx = 16'sh8000;
      r.gy = 16'sh8000;
      r.gz = 16'sh8000;
      r.ax = 16'sh7FFF;
      r.ay = 16'sh7FFF;
      r.az = 16'sh7FFF;
      r.t_us = 32'd0;
      r.t_ms = 32'd5;
      r.battery = 7'd127;
      send_request(r);
      // A refused single-row flush keeps the row for the next packet.
      r = make_request(isbp_pkg::ACT_SAMPLE, 32'd6, 1'b0);
      r.battery = 7'd0;
      send_request(r);
      send_request(make_request(isbp_pkg::ACT_SAMPLE, 32'd7, 1'b1));
   endtask

   task automatic test_connect_and_disconnect();
      write_register(isbp_pkg::CSR_LINK_MTU, 16'd37);
      write_register(isbp_pkg::CSR_FLUSH_TIMEOUT, 16'hFFFF);
      send_request(make_request(isbp_pkg::ACT_SAMPLE, 32'd10, 1'b1));
      send_request(make_request(isbp_pkg::ACT_CONNECT, 32'd11, 1'b1));
      send_request(make_request(isbp_pkg::ACT_SAMPLE, 32'd12, 1'b1));
      send_request(make_request(isbp_pkg::ACT_SAMPLE, 32'd13, 1'b1));
      send_request(make_request(isbp_pkg::ACT_DISCONNECT, 32'd14, 1'b1));
      send_request(make_request(isbp_pkg::ACT_CONNECT, 32'd15, 1'b1));
      send_request(make_request(isbp_pkg::ACT_SAMPLE, 32'd16, 1'b1));
      send_request(make_request(isbp_pkg::ACT_SAMPLE, 32'd17, 1'b1));
   endtask

   task automatic test_timeout_flush();
      write_register(isbp_pkg::CSR_LINK_MTU, 16'd517);
      write_register(isbp_pkg::CSR_FLUSH_TIMEOUT, 16'd10);
      send_request(make_request(isbp_pkg::ACT_SAMPLE, 32'd100, 1'b1));
      send_request(make_request(isbp_pkg::ACT_SAMPLE, 32'd103, 1'b1));
      send_request(make_request(isbp_pkg::ACT_PASS, 32'd112, 1'b1));
      send_request(make_request(isbp_pkg::ACT_PASS, 32'd500, 1'b1));
      send_request(make_request(isbp_pkg::ACT_SAMPLE, 32'hFFFF_FFF8, 1'b1));
      send_request(make_request(isbp_pkg::ACT_SAMPLE, 32'hFFFF_FFFA, 1'b1));
      send_request(make_request(isbp_pkg::ACT_PASS, 32'd3, 1'b1));
   endtask

   task automatic test_random_traffic();
      logic [15:0] mtu_word [8];
      logic [15:0] timeout_word [8];
      int unsigned accept_pct [8];
      int unsigned phase, n, roll;
      logic [1:0] act;
      logic [31:0] now_ms;
      mtu_word = '{16'd517, 16'd23, 16'hFFFF, 16'd37, 16'd241, 16'd25, 16'd517, 16'd61};
      timeout_word = '{16'hFFFF, 16'd15, 16'd0, 16'hFFFF, 16'd40, 16'd3, 16'd200, 16'hFFFF};
      accept_pct = '{50, 90, 95, 60, 90, 80, 100, 20};
      now_ms = 32'd1000;
      for (phase = 0; phase < 8; phase++) begin
         write_register(isbp_pkg::CSR_LINK_MTU, mtu_word[phase]);
         write_register(isbp_pkg::CSR_FLUSH_TIMEOUT, timeout_word[phase]);
         req_gap_max = (phase % 3 == 2 || phase == 6) ? 0 : 12;
         rsp_gap_max = (phase % 3 == 1 || phase == 6) ? 0 : 12;
         if (phase == 4) now_ms = 32'hFFFF_FF80;
         for (n = 0; n < 38; n++) begin
            roll = $urandom_range(0, 99);
            now_ms += $urandom_range(0, 3);
            if ($urandom_range(0, 49) == 0) now_ms = $urandom;
            if (!link_is_up && roll < 40) act = isbp_pkg::ACT_CONNECT;
            else if (roll < 3) act = isbp_pkg::ACT_DISCONNECT;
            else if (roll < 5) act = isbp_pkg::ACT_CONNECT;
            else if (roll < 15) act = isbp_pkg::ACT_PASS;
            else act = isbp_pkg::ACT_SAMPLE;
            send_request(make_request(act, now_ms, $urandom_range(0, 99) < accept_pct[phase]));
         end
      end
      req_gap_max = 12;
      rsp_gap_max = 12;
   endtask

   initial begin : row_checker
      packet_row_type want;
      int unsigned hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_rows.size() == 0) begin
               $display("%0t: row_number expected none, got %0d", $time, rsp_row_number);
               mismatch_count++;
            end else begin
               want = pending_rows.pop_front();
               check_field("first_index", want.first_index, rsp_first_index);
               check_field("first_time_us", want.first_us, rsp_first_time_us);
               check_field("battery_level", 32'(want.battery), 32'(rsp_battery_level));
               check_field("sample_total", 32'(want.total), 32'(rsp_sample_total));
               check_field("row_number", 32'(want.row), 32'(rsp_row_number));
               check_field("out_accel_x", 32'(want.ax), 32'(rsp_out_accel_x));
               check_field("out_accel_y", 32'(want.ay), 32'(rsp_out_accel_y));
               check_field("out_accel_z", 32'(want.az), 32'(rsp_out_accel_z));
               check_field("out_gyro_x", 32'(want.gx), 32'(rsp_out_gyro_x));
               check_field("out_gyro_y", 32'(want.gy), 32'(rsp_out_gyro_y));
               check_field("out_gyro_z", 32'(want.gz), 32'(rsp_out_gyro_z));
               check_field("last_row", 32'(want.last), 32'(rsp_last_row));
               rows_checked++;
            end
            hold = $urandom_range(0, rsp_gap_max);
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            hold--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = isbp_pkg::ACT_PASS;
      req_gyro_x = '0;
      req_gyro_y = '0;
      req_gyro_z = '0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      req_time_us = '0;
      req_time_ms = '0;
      req_battery_pct = '0;
      req_send_accepted = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = isbp_pkg::CSR_LINK_MTU;
      csr_wdata = '0;
      batch_len = 0;
      sample_seq = '0;
      batch_seq = '0;
      batch_us = '0;
      flush_ms = '0;
      link_is_up = 1'b0;
      mtu_reg = 10'd23;
      timeout_reg = isbp_pkg::TIMEOUT_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_link_down();
      test_field_extremes();
      test_connect_and_disconnect();
      test_timeout_flush();
      test_random_traffic();
      settle();

      $display("Sent %0d requests under %0d register writes; checked %0d rows of %0d packets",
               requests_sent, settings_written, rows_checked, packets_expected);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/isbp_pkg.sv
rtl/core/isbp_row_mem.sv
rtl/core/isbp_ctrl.sv
rtl/core/imu_sample_batch_packetizer_core.sv
tb/sv/imu_sample_batch_packetizer_core_test.sv
